FILE: hw/rtl/crcfe_pkg.sv
// Shared types, codes and the byte-wide CRC fold for the CRC-16 frame engine.
// Depends on nothing; every RTL file of the engine imports it.
package crcfe_pkg;

  localparam logic [15:0] CRC_POLY_REFLECTED = 16'h8408;
  localparam logic [15:0] CRC_SEED_RESET     = 16'hFFFF;

  // The output queue holds the three results that one byte can cause,
  // plus one beat that may still be waiting downstream.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_COMPUTE = 2'd0,
    MODE_VERIFY  = 2'd1,
    MODE_APPEND  = 2'd2
  } mode_t;

  typedef enum logic {
    REG_MODE = 1'b0,
    REG_SEED = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_CRC_BYTE = 2'd1,
    KIND_REPORT   = 2'd2,
    KIND_VERIFY   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] crc;
    logic        ok;
    logic        last;
  } result_t;

  // Folds one byte into the reflected CRC, least significant bit first.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                           input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFLECTED) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/crc16_reflected_frame_engine.sv
// CRC-16 (reflected polynomial 0x8408, LSB first) frame engine top level.
// Depends on crcfe_pkg for types, codes and the CRC fold function.
//
// The engine takes one packet byte per cycle with first and last markers and
// keeps its CRC, held trailer bytes and fill state in registers, updating them
// in the same cycle a byte beat is accepted. Every result that a byte causes
// (none, one, or three for the last byte in append mode) is written at once
// into a four-entry output queue, which drains one beat per cycle while the
// output is not stalled. A byte is taken whenever the queue holds at most
// one beat, so the sustained rate is one byte per cycle as long as the output
// side keeps up; the end of an append packet queues three beats, and the input
// stalls until the queue holds at most one beat again. Configuration writes are
// always accepted and should be issued only while the engine is idle.
module crc16_reflected_frame_engine
  import crcfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Byte input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  out_byte,
  output logic [15:0] crc_value,
  output logic        crc_ok,
  output logic        out_last,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  mode_t       mode;
  logic [15:0] crc_seed;
  logic [15:0] crc_acc;
  logic [15:0] crc_acc_next;
  logic [7:0]  held0;
  logic [7:0]  held0_next;
  logic [7:0]  held1;
  logic [7:0]  held1_next;
  logic [1:0]  held_count;
  logic [1:0]  held_count_next;

  result_t               queue [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_CW-1:0]   count;

  logic        in_accept;
  logic        out_pop;
  logic [1:0]  push_n;
  result_t     ent0;
  result_t     ent1;
  result_t     ent2;

  // Start point of this byte, after an optional restart from the seed.
  logic [15:0] crc_start;
  logic [1:0]  held_start;
  logic [7:0]  fold_in;
  logic [15:0] crc_folded;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_COMPUTE;
      crc_seed <= CRC_SEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE: mode     <= mode_t'(cfg_data[1:0]);
        REG_SEED: crc_seed <= cfg_data;
        default:  ;
      endcase
    end
  end

  assign in_stall  = (count > QUEUE_CW'(1));
  assign in_accept = in_valid && !in_stall;
  assign out_valid = (count != '0);
  assign out_pop   = out_valid && !out_stall;

  assign crc_start  = first_byte ? crc_seed : crc_acc;
  assign held_start = first_byte ? 2'd0 : held_count;
  // In verify mode the oldest held byte is folded; otherwise the new byte.
  assign fold_in    = (mode == MODE_VERIFY) ? held0 : data_byte;
  assign crc_folded = crc_fold(crc_start, fold_in);

  always_comb begin
    crc_acc_next    = crc_start;
    held0_next      = held0;
    held1_next      = held1;
    held_count_next = 2'd0;
    push_n          = 2'd0;
    ent0            = '{kind: KIND_DATA, data: 8'h00, crc: 16'h0000, ok: 1'b0, last: 1'b0};
    ent1            = ent0;
    ent2            = ent0;
    case (mode)
      MODE_VERIFY: begin
        if (held_start >= 2'd2) begin
          crc_acc_next    = crc_folded;
          held0_next      = held1;
          held1_next      = data_byte;
          held_count_next = held_start;
        end else begin
          if (held_start[0]) begin
            held1_next = data_byte;
          end else begin
            held0_next = data_byte;
          end
          held_count_next = held_start + 2'd1;
        end
        if (last_byte) begin
          push_n    = 2'd1;
          ent0.kind = KIND_VERIFY;
          ent0.crc  = crc_acc_next;
          ent0.ok   = (held_count_next >= 2'd2) &&
                      ({held1_next, held0_next} == crc_acc_next);
          ent0.last = 1'b1;
          held_count_next = 2'd0;
        end
      end
      MODE_APPEND: begin
        crc_acc_next = crc_folded;
        ent0.kind    = KIND_DATA;
        ent0.data    = data_byte;
        ent1.kind    = KIND_CRC_BYTE;
        ent1.data    = crc_folded[7:0];
        ent2.kind    = KIND_CRC_BYTE;
        ent2.data    = crc_folded[15:8];
        ent2.last    = 1'b1;
        push_n       = last_byte ? 2'd3 : 2'd1;
      end
      default: begin
        // Compute mode; the unused mode code behaves the same way.
        crc_acc_next = crc_folded;
        if (last_byte) begin
          push_n    = 2'd1;
          ent0.kind = KIND_REPORT;
          ent0.crc  = crc_folded;
          ent0.last = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc    <= CRC_SEED_RESET;
      held0      <= 8'h00;
      held1      <= 8'h00;
      held_count <= 2'd0;
    end else if (in_accept) begin
      crc_acc    <= crc_acc_next;
      held0      <= held0_next;
      held1      <= held1_next;
      held_count <= held_count_next;
    end
  end

  // Output queue: up to three beats are written per accepted byte.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (push_n > 2'd0) begin
        queue[wr_ptr] <= ent0;
      end
      if (push_n > 2'd1) begin
        queue[wr_ptr + QUEUE_AW'(1)] <= ent1;
      end
      if (push_n > 2'd2) begin
        queue[wr_ptr + QUEUE_AW'(2)] <= ent2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_accept) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(push_n);
      end
      if (out_pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      count <= count + (in_accept ? QUEUE_CW'(push_n) : QUEUE_CW'(0))
                     - QUEUE_CW'(out_pop);
    end
  end

  assign result_kind = queue[rd_ptr].kind;
  assign out_byte    = queue[rd_ptr].data;
  assign crc_value   = queue[rd_ptr].crc;
  assign crc_ok      = queue[rd_ptr].ok;
  assign out_last    = queue[rd_ptr].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("output queue holds more beats than its depth");

  a_append_tail: assert property (@(posedge clk) disable iff (rst)
    in_accept && (mode == MODE_APPEND) && last_byte |=> count >= QUEUE_CW'(2))
    else $error("append packet end did not queue its CRC bytes");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd3)
    else $error("held byte count out of range");

  a_verify_end: assert property (@(posedge clk) disable iff (rst)
    in_accept && (mode == MODE_VERIFY) && last_byte |=> held_count == 2'd0)
    else $error("verify packet ended with held bytes left");

  a_pop_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with mismatched pointers");

endmodule
